// ----- hw/rtl/zrt_pkg.sv -----
package zrt_pkg;

    localparam int MAX_LEN = 64;
    localparam int CHAR_W  = 8;
    localparam int ROW_W   = 7;
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    // zigzag period 2R-2 for R up to 2^ROW_W-1
    localparam int PER_W   = ROW_W + 1;
    localparam int SUM_W   = ((ADDR_W > PER_W) ? ADDR_W : PER_W) + 1;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [ROW_W-1:0]  t_rows;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [PER_W-1:0]  t_per;
    typedef logic [SUM_W-1:0]  t_sum;

endpackage

// ----- hw/rtl/zrt_in_if.sv -----
interface zrt_in_if;
    import zrt_pkg::*;

    logic  valid;
    logic  ready;
    t_char char_in;
    logic  last_in;

    modport source(output valid, char_in, last_in, input ready);
    modport sink(input valid, char_in, last_in, output ready);
endinterface

// ----- hw/rtl/zrt_out_if.sv -----
interface zrt_out_if;
    import zrt_pkg::*;

    logic  valid;
    logic  ready;
    t_char char_out;
    logic  last_out;
    logic  overflow;

    modport source(output valid, char_out, last_out, overflow, input ready);
    modport sink(input valid, char_out, last_out, overflow, output ready);
endinterface

// ----- hw/rtl/zrt_ram.sv -----
module zrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ----- hw/rtl/zigzag_row_transposer_top.sv -----
// Rail fence (zigzag) reorderer. Message bytes are taken one per cycle and
// written into a 64-entry byte RAM; bytes beyond 64 are dropped and flag
// overflow on every result of that message. The item carrying last_in ends
// input: the read state fetches the first byte before the first result is
// shown; results then follow at one per cycle while the sink is ready, row 0
// first, each row in original order. The single RAM read port sets the
// emission rate; input is not accepted during emission. row_count (0 acts as
// 1) is sampled with the final byte.
module zigzag_row_transposer_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  zrt_pkg::t_rows       i_cfg_data,
    zrt_in_if.sink               i_in,
    zrt_out_if.source            o_out
);
    import zrt_pkg::*;

    typedef enum logic [1:0] {S_IN, S_RD, S_OUT} t_state;

    t_state r_state, n_state;
    t_rows  r_row_count;
    t_cnt   r_cnt, n_cnt;
    logic   r_ovf, n_ovf;
    t_cnt   r_len, n_len;
    t_rows  r_rows, n_rows;
    t_per   r_period, n_period;
    t_addr  r_row, n_row;
    t_addr  r_idx, n_idx;
    logic   r_dir, n_dir;
    t_addr  r_k, n_k;

    logic  in_acc, out_acc, full, final_out, single, edge_row;
    t_cnt  cnt_inc;
    t_rows rows_eff;
    t_per  step;
    t_sum  cand;
    t_addr nxt_idx, nxt_row;
    logic  nxt_dir;
    logic  ram_we, ram_re;
    t_addr ram_raddr;
    t_char ram_rdata;

    assign in_acc    = i_in.valid && i_in.ready;
    assign out_acc   = o_out.valid && o_out.ready;
    assign full      = (r_cnt == CNT_W'(MAX_LEN));
    assign cnt_inc   = full ? r_cnt : r_cnt + 1'b1;
    assign rows_eff  = (r_row_count == '0) ? ROW_W'(1) : r_row_count;
    assign final_out = (CNT_W'(r_k) == r_len - 1'b1);

    // next position along the current row; wrap to the next row's head
    assign single   = (r_rows == ROW_W'(1));
    assign edge_row = (r_row == '0) || (ROW_W'(r_row) == r_rows - 1'b1);

    always_comb begin
        priority if (single) begin
            step = PER_W'(1);
        end else if (edge_row) begin
            step = r_period;
        end else if (r_dir) begin
            step = PER_W'(r_row) << 1;
        end else begin
            step = r_period - (PER_W'(r_row) << 1);
        end
        cand = SUM_W'(r_idx) + SUM_W'(step);
        if (cand < SUM_W'(r_len)) begin
            nxt_idx = cand[ADDR_W-1:0];
            nxt_row = r_row;
            nxt_dir = ~r_dir;
        end else begin
            nxt_idx = r_row + 1'b1;
            nxt_row = r_row + 1'b1;
            nxt_dir = 1'b0;
        end
    end

    assign ram_we    = in_acc && !full;
    assign ram_re    = (r_state == S_RD) || (out_acc && !final_out);
    assign ram_raddr = (r_state == S_RD) ? '0 : nxt_idx;

    zrt_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_LEN)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata (i_in.char_in),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_in.ready     = (r_state == S_IN);
    assign o_out.valid    = (r_state == S_OUT);
    assign o_out.char_out = ram_rdata;
    assign o_out.last_out = final_out;
    assign o_out.overflow = r_ovf;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ovf    = r_ovf;
        n_len    = r_len;
        n_rows   = r_rows;
        n_period = r_period;
        n_row    = r_row;
        n_idx    = r_idx;
        n_dir    = r_dir;
        n_k      = r_k;
        unique case (r_state)
            S_IN: begin
                if (in_acc) begin
                    n_cnt = cnt_inc;
                    if (full) begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.last_in) begin
                        n_len    = cnt_inc;
                        n_rows   = rows_eff;
                        n_period = (PER_W'(rows_eff) << 1) - PER_W'(2);
                        n_state  = S_RD;
                    end
                end
            end
            S_RD: begin
                n_row   = '0;
                n_idx   = '0;
                n_dir   = 1'b0;
                n_k     = '0;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_acc) begin
                    if (final_out) begin
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IN;
                    end else begin
                        n_idx = nxt_idx;
                        n_row = nxt_row;
                        n_dir = nxt_dir;
                        n_k   = r_k + 1'b1;
                    end
                end
            end
            default: n_state = S_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IN;
            r_row_count <= ROW_W'(1);
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            if (i_cfg_we) begin
                r_row_count <= i_cfg_data;
            end
        end
        r_len    <= n_len;
        r_rows   <= n_rows;
        r_period <= n_period;
        r_row    <= n_row;
        r_idx    <= n_idx;
        r_dir    <= n_dir;
        r_k      <= n_k;
    end
endmodule

// ----- hw/rtl/zrt_checker.sv -----
module zrt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_last,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_last,
    input logic i_out_overflow
);
    // input and emission never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready during emission");

    a_last_stops_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_last) |=> !i_in_ready)
        else $error("input still ready after final item");

    a_last_ends_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_last) |=> !i_out_valid)
        else $error("result shown after last result");

    // overflow is a per-message flag
    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |=> $stable(i_out_overflow))
        else $error("overflow changed within a message");
endmodule

bind zigzag_row_transposer_top zrt_checker u_zrt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_last      (i_in.last_in),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_last     (o_out.last_out),
    .i_out_overflow (o_out.overflow)
);

// ----- test/tb_zigzag_row_transposer_top.sv -----
`timescale 1ns / 1ps
module tb_zigzag_row_transposer_top;
    import zrt_pkg::*;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int RANDOM_BUDGET = 130;
    localparam int LONG_HOLD     = 80;
    localparam int SETTLE        = 6;

    typedef struct {
        t_char ch;
        logic  fin;
        logic  ovf;
    } t_rail_byte;

    // Rail fence predictor plus the queue of bytes still owed by the block.
    class rail_fence_scoreboard;
        t_char      msg_bytes[MAX_LEN];
        int         n_stored;
        bit         dropped;
        t_rows      rows_cfg;
        t_rail_byte expected_q[$];
        int         errors;
        int         n_items;
        int         n_results;
        int         n_msgs;
        int         n_ovf_msgs;

        function new();
            n_stored   = 0;
            dropped    = 1'b0;
            rows_cfg   = t_rows'(1);
            errors     = 0;
            n_items    = 0;
            n_results  = 0;
            n_msgs     = 0;
            n_ovf_msgs = 0;
        endfunction

        function void set_rows(t_rows v);
            rows_cfg = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int zigzag_row(int pos, int rows);
            int period;
            int p;
            if (rows <= 1) return 0;
            period = 2 * rows - 2;
            p = pos % period;
            return (p < rows) ? p : period - p;
        endfunction

        function void note_input(t_char ch, logic fin);
            int rows;
            int k;
            t_rail_byte e;
            n_items++;
            if (n_stored < MAX_LEN) begin
                msg_bytes[n_stored] = ch;
                n_stored++;
            end else begin
                dropped = 1'b1;
            end
            if (!fin) return;
            // zero rows behaves as one
            rows = (rows_cfg == 0) ? 1 : int'(rows_cfg);
            k = 0;
            for (int r = 0; r < rows && k < n_stored; r++) begin
                for (int i = 0; i < n_stored; i++) begin
                    if (zigzag_row(i, rows) == r) begin
                        e.ch  = msg_bytes[i];
                        e.fin = 1'b0;
                        e.ovf = dropped;
                        expected_q.push_back(e);
                        k++;
                    end
                end
            end
            expected_q[expected_q.size() - 1].fin = 1'b1;
            n_msgs++;
            if (dropped) n_ovf_msgs++;
            n_stored = 0;
            dropped  = 1'b0;
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(t_char ch, logic fin, logic ovf);
            t_rail_byte e;
            n_results++;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result %0d (char %02h) with none expected",
                                          n_results, ch));
                return;
            end
            e = expected_q.pop_front();
            if (ch !== e.ch)
                report_mismatch($sformatf("result %0d char_out %02h, want %02h",
                                          n_results, ch, e.ch));
            if (fin !== e.fin)
                report_mismatch($sformatf("result %0d last_out %b, want %b",
                                          n_results, fin, e.fin));
            if (ovf !== e.ovf)
                report_mismatch($sformatf("result %0d overflow %b, want %b",
                                          n_results, ovf, e.ovf));
        endtask
    endclass

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  i_cfg_we;
    t_rows i_cfg_data;

    zrt_in_if  in_if();
    zrt_out_if out_if();

    rail_fence_scoreboard sb = new();

    bit hold_req = 1'b0;
    bit calm     = 1'b0;
    int cycles   = 0;

    zigzag_row_transposer_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always #10 i_clk = ~i_clk;

    task automatic send_item(input t_char ch, input logic fin);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.char_in <= ch;
        in_if.last_in <= fin;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_input(ch, fin);
    endtask

    task automatic send_msg(input t_char m[$], input bit hold_at_end);
        foreach (m[i]) begin
            // receiver backs off as emission starts, next message piles up
            if (hold_at_end && i == m.size() - 1) hold_req = 1'b1;
            send_item(m[i], i == m.size() - 1);
        end
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_rows(input t_rows v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_rows(v);
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready)
                sb.check_result(out_if.char_out, out_if.last_out, out_if.overflow);
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD - 1;
                out_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 4);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycles, sb.pending());
        $display("tb_zigzag_row_transposer_top: done, errors");
        $finish;
    end

    initial begin : stimulus
        t_char m[$];
        int    rows_plan[12];
        int    rand_items;
        int    phase;
        int    rows;
        int    len;
        int    n_in_phase;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= '0;
        in_if.valid   <= 1'b0;
        in_if.char_in <= '0;
        in_if.last_in <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset row count: pass through
        m = '{8'h00, 8'hFF, 8'h5A};
        send_msg(m, 1'b0);
        m = '{8'hA5};
        send_msg(m, 1'b0);
        drain();

        write_rows(t_rows'(3));
        m = '{8'h52, 8'h41, 8'h49, 8'h4C, 8'h46, 8'h45, 8'h4E, 8'h43, 8'h45};
        send_msg(m, 1'b0);
        drain();

        write_rows(t_rows'(0));
        m = '{8'h80, 8'h01};
        send_msg(m, 1'b0);
        drain();

        write_rows(t_rows'(2));
        m = '{8'h7F, 8'h00, 8'hFF, 8'h10, 8'hEE};
        send_msg(m, 1'b0);
        drain();

        rows_plan  = '{2, 33, 127, 65, 64, 63, 5, 3, 0, 1, 4, 7};
        rand_items = 0;
        phase      = 0;
        while (rand_items < RANDOM_BUDGET) begin
            if (phase < 12)
                rows = rows_plan[phase];
            else if ($urandom_range(0, 7) == 0)
                rows = $urandom_range(0, 127);
            else
                rows = $urandom_range(1, 10);
            calm = (rand_items >= RANDOM_BUDGET - 40);
            write_rows(t_rows'(rows));
            n_in_phase = (phase == 0) ? 2 : $urandom_range(1, 2);
            for (int j = 0; j < n_in_phase; j++) begin
                if (phase == 1 && j == 0)
                    len = MAX_LEN + 2;      // buffer fills, then two bytes dropped
                else if ($urandom_range(0, 4) == 0)
                    len = $urandom_range(11, 24);
                else
                    len = $urandom_range(1, 10);
                m.delete();
                repeat (len) m.push_back(t_char'($urandom_range(0, 255)));
                send_msg(m, phase == 0 && j == 0);
                rand_items += len;
            end
            drain();
            phase++;
        end

        $display("%0d items in %0d messages (%0d overflowing), %0d results checked",
                 sb.n_items, sb.n_msgs, sb.n_ovf_msgs, sb.n_results);
        $display("rows 0..127 incl. zigzag turns, full buffer, dropped final byte, stalls");
        if (sb.errors == 0)
            $display("tb_zigzag_row_transposer_top: done, clean");
        else
            $display("tb_zigzag_row_transposer_top: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/zrt_pkg.sv
hw/rtl/zrt_in_if.sv
hw/rtl/zrt_out_if.sv
hw/rtl/zrt_ram.sv
hw/rtl/zigzag_row_transposer_top.sv
hw/rtl/zrt_checker.sv
test/tb_zigzag_row_transposer_top.sv
